// File: rtl/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and widths for the 3x3 fixed-point matrix inverse.
// No dependencies; imported by every module of the block.
package mi3_pkg;

    localparam int NUM_ENT   = 9;   // matrix entries
    localparam int Q_W       = 32;  // Q16.16 word
    localparam int PROD_W    = 64;  // 32x32 product
    localparam int ADJ_W     = 65;  // exact cofactor, signed
    localparam int MAG_W     = 64;  // cofactor magnitude
    localparam int DET_W     = 97;  // exact determinant, signed
    localparam int DMAG_W    = 96;  // determinant magnitude
    localparam int DIV_STEPS = 32;  // quotient bits below the overflow check

    typedef logic [NUM_ENT-1:0][Q_W-1:0]    t_mat;
    typedef logic [NUM_ENT-1:0][ADJ_W-1:0]  t_adj;
    typedef logic [NUM_ENT-1:0][MAG_W-1:0]  t_amag;
    typedef logic [NUM_ENT-1:0][DMAG_W-1:0] t_rem;
    typedef logic [2:0][Q_W-1:0]            t_col;

    // determinant-side results that ride alongside the divider
    typedef struct packed {
        logic [Q_W-1:0] dout;
        logic           sing;
        logic           dclip;
    } t_side;

endpackage : mi3_pkg
`default_nettype wire

// File: rtl/mi3_adj.sv
`timescale 1ns / 1ps
`default_nettype none
// Cofactor stages: eighteen 32x32 products, then pairwise differences.
// Depends on mi3_pkg.
module mi3_adj import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_mat i_mat,
    output logic      o_vld,
    output t_adj      o_adj,
    output t_col      o_col
);

    // cofactor k = mat[MUL_A[2k]]*mat[MUL_B[2k]] - mat[MUL_A[2k+1]]*mat[MUL_B[2k+1]]
    localparam logic [3:0] MUL_A [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam logic [3:0] MUL_B [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    logic signed [PROD_W-1:0] n_pp [18];
    logic signed [PROD_W-1:0] r_pp [18];
    t_col r_col1, r_col2;
    t_adj r_adj;
    logic r_vld1, r_vld2;

    always_comb begin
        for (int k = 0; k < 18; k++) begin
            n_pp[k] = $signed(i_mat[MUL_A[k]]) * $signed(i_mat[MUL_B[k]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp   <= n_pp;
            r_col1 <= {i_mat[6], i_mat[3], i_mat[0]};
            r_col2 <= r_col1;
            for (int k = 0; k < NUM_ENT; k++) begin
                r_adj[k] <= {r_pp[2*k][PROD_W-1], r_pp[2*k]}
                          - {r_pp[2*k+1][PROD_W-1], r_pp[2*k+1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_adj = r_adj;
    assign o_col = r_col2;

endmodule : mi3_adj
`default_nettype wire

// File: rtl/mi3_det.sv
`timescale 1ns / 1ps
`default_nettype none
// Determinant stages: magnitudes, split products, signed terms, sum, abs,
// then per-lane overflow checks and the saturated det_out. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_adj  i_adj,
    input  wire t_col  i_col,
    output logic       o_vld,
    output t_amag      o_amag,
    output logic [NUM_ENT-1:0] o_neg,
    output logic [NUM_ENT-1:0] o_ovf,
    output logic [DMAG_W-1:0]  o_dmag,
    output t_side      o_side
);

    // stage 3
    t_amag r_amag3;
    logic [NUM_ENT-1:0] r_aneg3;
    t_col  r_cm3;
    logic [2:0] r_tneg3;
    // stage 4
    t_amag r_amag4;
    logic [NUM_ENT-1:0] r_aneg4;
    logic [2:0][PROD_W-1:0] r_pl4, r_ph4;
    logic [2:0] r_tneg4;
    // stage 5
    t_amag r_amag5;
    logic [NUM_ENT-1:0] r_aneg5;
    logic [2:0][DET_W-1:0] r_term5;
    // stage 6
    t_amag r_amag6;
    logic [NUM_ENT-1:0] r_aneg6;
    logic [DET_W-1:0] r_det6;
    // stage 7
    t_amag r_amag7;
    logic [NUM_ENT-1:0] r_aneg7;
    logic [DMAG_W-1:0] r_dmag7;
    logic r_dneg7, r_zero7;
    // stage 8
    t_amag r_amag8;
    logic [NUM_ENT-1:0] r_neg8, r_ovf8;
    logic [DMAG_W-1:0] r_dmag8;
    t_side r_side8;
    logic [5:0] r_vld;

    logic [2:0][DMAG_W-1:0] n_t;
    logic [PROD_W-1:0] n_dint;
    t_side n_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = {32'b0, r_pl4[i]} + {r_ph4[i], 32'b0};
        end
    end

    // |det| in Q16.16 (low 32 bits dropped), signed and saturated to Q16.16
    always_comb begin
        n_dint       = r_dmag7[DMAG_W-1:32];
        n_side.sing  = r_zero7;
        n_side.dclip = 1'b0;
        if (r_dneg7) begin
            if (n_dint > 64'h8000_0000) begin
                n_side.dclip = 1'b1;
                n_side.dout  = 32'h8000_0000;
            end else begin
                n_side.dout  = 32'(0 - n_dint[31:0]);
            end
        end else if (n_dint > 64'h7FFF_FFFF) begin
            n_side.dclip = 1'b1;
            n_side.dout  = 32'h7FFF_FFFF;
        end else begin
            n_side.dout  = n_dint[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_ENT; k++) begin
                r_aneg3[k] <= i_adj[k][ADJ_W-1];
                r_amag3[k] <= i_adj[k][ADJ_W-1] ? MAG_W'(0 - i_adj[k]) : i_adj[k][MAG_W-1:0];
            end
            for (int i = 0; i < 3; i++) begin
                r_cm3[i]   <= i_col[i][Q_W-1] ? 32'(0 - i_col[i]) : i_col[i];
                r_tneg3[i] <= i_col[i][Q_W-1] ^ i_adj[i][ADJ_W-1];
            end

            r_amag4 <= r_amag3;
            r_aneg4 <= r_aneg3;
            r_tneg4 <= r_tneg3;
            for (int i = 0; i < 3; i++) begin
                r_pl4[i] <= r_cm3[i] * r_amag3[i][31:0];
                r_ph4[i] <= r_cm3[i] * r_amag3[i][63:32];
            end

            r_amag5 <= r_amag4;
            r_aneg5 <= r_aneg4;
            for (int i = 0; i < 3; i++) begin
                r_term5[i] <= r_tneg4[i] ? (0 - {1'b0, n_t[i]}) : {1'b0, n_t[i]};
            end

            r_amag6 <= r_amag5;
            r_aneg6 <= r_aneg5;
            r_det6  <= r_term5[0] + r_term5[1] + r_term5[2];

            r_amag7 <= r_amag6;
            r_aneg7 <= r_aneg6;
            r_dneg7 <= r_det6[DET_W-1];
            r_zero7 <= (r_det6 == '0);
            r_dmag7 <= r_det6[DET_W-1] ? DMAG_W'(0 - r_det6) : r_det6[DMAG_W-1:0];

            r_amag8 <= r_amag7;
            r_dmag8 <= r_dmag7;
            r_side8 <= n_side;
            for (int k = 0; k < NUM_ENT; k++) begin
                r_neg8[k] <= r_aneg7[k] ^ r_dneg7;
                // quotient would reach 2^32
                r_ovf8[k] <= ({32'b0, r_amag7[k]} >= r_dmag7);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    assign o_vld  = r_vld[5];
    assign o_amag = r_amag8;
    assign o_neg  = r_neg8;
    assign o_ovf  = r_ovf8;
    assign o_dmag = r_dmag8;
    assign o_side = r_side8;

endmodule : mi3_det
`default_nettype wire

// File: rtl/mi3_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Nine restoring dividers side by side, one quotient bit per stage,
// sharing the divisor line. Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_amag i_amag,
    input  wire logic [NUM_ENT-1:0] i_neg,
    input  wire logic [NUM_ENT-1:0] i_ovf,
    input  wire logic [DMAG_W-1:0]  i_dmag,
    input  wire t_side i_side,
    output logic       o_vld,
    output t_mat       o_q,
    output logic [NUM_ENT-1:0] o_neg,
    output logic [NUM_ENT-1:0] o_ovf,
    output t_side      o_side
);

    t_rem               r_rem  [DIV_STEPS];
    t_mat               r_q    [DIV_STEPS];
    logic [DMAG_W-1:0]  r_dm   [DIV_STEPS];
    logic [NUM_ENT-1:0] r_neg  [DIV_STEPS];
    logic [NUM_ENT-1:0] r_ovf  [DIV_STEPS];
    t_side              r_side [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_vld;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        t_rem               p_rem, n_rem;
        t_mat               p_q, n_q;
        logic [DMAG_W-1:0]  p_dm;
        logic [NUM_ENT-1:0] p_neg, p_ovf;
        t_side              p_side;
        logic               p_vld;

        if (s == 0) begin : g_first
            always_comb begin
                for (int k = 0; k < NUM_ENT; k++) begin
                    p_rem[k] = {32'b0, i_amag[k]};
                end
            end
            assign p_q    = '0;
            assign p_dm   = i_dmag;
            assign p_neg  = i_neg;
            assign p_ovf  = i_ovf;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_q    = r_q[s-1];
            assign p_dm   = r_dm[s-1];
            assign p_neg  = r_neg[s-1];
            assign p_ovf  = r_ovf[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        always_comb begin
            logic [DMAG_W:0] sh;
            logic            ge;
            for (int k = 0; k < NUM_ENT; k++) begin
                sh       = {p_rem[k], 1'b0};
                ge       = (sh >= {1'b0, p_dm});
                n_rem[k] = ge ? DMAG_W'(sh - {1'b0, p_dm}) : sh[DMAG_W-1:0];
                n_q[k]   = {p_q[k][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_dm[s]   <= p_dm;
                r_neg[s]  <= p_neg;
                r_ovf[s]  <= p_ovf;
                r_side[s] <= p_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_q    = r_q[DIV_STEPS-1];
    assign o_neg  = r_neg[DIV_STEPS-1];
    assign o_ovf  = r_ovf[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule : mi3_div
`default_nettype wire

// File: rtl/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the 3x3 Q16.16 matrix inverse (adjugate over determinant).
// Depends on mi3_pkg, mi3_adj, mi3_det, mi3_div.
//
//  channel   dir  tdata                              tuser
//  s_axis    in   a00..a22, 9 x 32 bits              -
//  m_axis    out  inv00..inv22, det_out, 10 x 32     singular, saturated
//
// One matrix a cycle when the output is not stalled; the pipe has 2 cofactor,
// 6 determinant and 32 divider stages and 1 output register.
// Every stage advances together; the output register stalls the whole pipe
// when full and not taken, so no beat is lost or repeated.
// Reset (synchronous, low) clears the valid bits only.
module matrix_inverse_3x3_unit import mi3_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [287:0] i_s_axis_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [319:0]      o_m_axis_tdata,   // inv00..inv22, det_out
    output logic [1:0]        o_m_axis_tuser    // singular, saturated
);

    logic en;
    logic adj_vld, det_vld, div_vld;
    t_adj adj;
    t_col col;
    t_amag amag;
    logic [NUM_ENT-1:0] d_neg, d_ovf, q_neg, q_ovf;
    logic [DMAG_W-1:0] dmag;
    t_side d_side, q_side;
    t_mat  q;

    t_mat r_inv, n_inv;
    logic [Q_W-1:0] r_dout;
    logic r_sing, r_sat, n_sat;
    logic r_ovalid;

    assign en = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    mi3_adj u_adj (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_s_axis_tvalid), .i_mat(t_mat'(i_s_axis_tdata)),
        .o_vld(adj_vld), .o_adj(adj), .o_col(col)
    );

    mi3_det u_det (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(adj_vld), .i_adj(adj), .i_col(col),
        .o_vld(det_vld), .o_amag(amag), .o_neg(d_neg), .o_ovf(d_ovf),
        .o_dmag(dmag), .o_side(d_side)
    );

    mi3_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(det_vld), .i_amag(amag), .i_neg(d_neg), .i_ovf(d_ovf),
        .i_dmag(dmag), .i_side(d_side),
        .o_vld(div_vld), .o_q(q), .o_neg(q_neg), .o_ovf(q_ovf), .o_side(q_side)
    );

    // sign and saturate; a singular matrix gives all zeros
    always_comb begin
        n_sat = q_side.dclip;
        for (int k = 0; k < NUM_ENT; k++) begin
            if (q_ovf[k]) begin
                n_sat    = 1'b1;
                n_inv[k] = q_neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (q_neg[k]) begin
                if (q[k] > 32'h8000_0000) begin
                    n_sat    = 1'b1;
                    n_inv[k] = 32'h8000_0000;
                end else begin
                    n_inv[k] = 32'(0 - q[k]);
                end
            end else if (q[k][Q_W-1]) begin
                n_sat    = 1'b1;
                n_inv[k] = 32'h7FFF_FFFF;
            end else begin
                n_inv[k] = q[k];
            end
        end
        if (q_side.sing) begin
            n_sat = 1'b0;
            n_inv = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inv  <= n_inv;
            r_dout <= q_side.dout;
            r_sing <= q_side.sing;
            r_sat  <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= div_vld;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_dout, r_inv};
    assign o_m_axis_tuser  = {r_sat, r_sing};

endmodule : matrix_inverse_3x3_unit
`default_nettype wire
